/* hw/rtl/dqdel_pkg.sv */
// Package for the deque with delete by value.
// Holds sizes, action codes, controller states, the result word and the slot helper.
// Depends on nothing.
`default_nettype none

package dqdel_pkg;

    localparam int DEPTH     = 16;
    localparam int ITEM_BITS = 32;
    localparam int WORD_W    = 32;
    localparam int AW        = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_PREPEND = 2'd0,
        ACT_APPEND  = 2'd1,
        ACT_DEQUEUE = 2'd2,
        ACT_DELETE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEQ,
        ST_DEL_RD,
        ST_DEL_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic                 status;
        logic [ITEM_BITS-1:0] item;
        logic                 found;
        logic [CNT_W-1:0]     length;
    } result_t;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                              input logic [CNT_W-1:0] pos);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(front) + (CNT_W + 1)'(pos);
        if (s >= (CNT_W + 1)'(DEPTH))
            s = s - (CNT_W + 1)'(DEPTH);
        return s[AW-1:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/dqdel_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module dqdel_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hw/rtl/dqdel_ctrl.sv */
// Sequencer for the deque: pointer state, memory accesses, scan and shift for delete.
// Depends on dqdel_pkg and drives one dqdel_ram through its port signals.
`default_nettype none

module dqdel_ctrl
    import dqdel_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           action,
    input  wire logic [ITEM_BITS-1:0] item,
    output logic                      res_valid,
    input  wire logic                 res_take,
    output result_t                   res,
    output logic                      wr_en,
    output logic      [AW-1:0]        wr_addr,
    output logic      [ITEM_BITS-1:0] wr_data,
    output logic                      rd_en,
    output logic      [AW-1:0]        rd_addr,
    input  wire logic [ITEM_BITS-1:0] rd_data
);

    state_t               state_reg, state_next;
    logic [AW-1:0]        front_reg, front_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic [ITEM_BITS-1:0] item_reg, item_next;
    result_t              res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        front_next = front_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        item_next  = item_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = slot_of(front_reg, pos_reg);
        wr_data    = rd_data;
        rd_en      = 1'b0;
        rd_addr    = slot_of(front_reg, pos_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next       = item;
                    pos_next        = '0;
                    res_next        = '0;
                    res_next.length = count_reg;
                    state_next      = ST_RESP;
                    case (action_t'(action))
                        ACT_PREPEND:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                                res_next.status = 1'b1;
                            else
                            begin
                                front_next = (front_reg == '0) ? AW'(DEPTH - 1)
                                                               : front_reg - 1'b1;
                                wr_en      = 1'b1;
                                wr_addr    = front_next;
                                wr_data    = item;
                                count_next = count_reg + 1'b1;
                                res_next.length = count_next;
                            end
                        end
                        ACT_APPEND:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                                res_next.status = 1'b1;
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = slot_of(front_reg, count_reg);
                                wr_data    = item;
                                count_next = count_reg + 1'b1;
                                res_next.length = count_next;
                            end
                        end
                        ACT_DEQUEUE:
                        begin
                            if (count_reg == '0)
                                res_next.status = 1'b1;
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = front_reg;
                                state_next = ST_DEQ;
                            end
                        end
                        default:
                            state_next = ST_DEL_RD;
                    endcase
                end
            end
            ST_DEQ:
            begin
                res_next.item   = rd_data;
                front_next      = slot_of(front_reg, CNT_W'(1));
                count_next      = count_reg - 1'b1;
                res_next.length = count_next;
                state_next      = ST_RESP;
            end
            ST_DEL_RD:
            begin
                if (pos_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_DEL_CMP;
                end
                else
                    state_next = ST_RESP;
            end
            ST_DEL_CMP:
            begin
                if (rd_data == item_reg)
                    state_next = ST_SHIFT_RD;
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = ST_DEL_RD;
                end
            end
            ST_SHIFT_RD:
            begin
                if ((CNT_W + 1)'(pos_reg) + 1'b1 < (CNT_W + 1)'(count_reg))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = slot_of(front_reg, pos_reg + 1'b1);
                    state_next = ST_SHIFT_WR;
                end
                else
                begin
                    count_next      = count_reg - 1'b1;
                    res_next.found  = 1'b1;
                    res_next.length = count_next;
                    state_next      = ST_RESP;
                end
            end
            ST_SHIFT_WR:
            begin
                wr_en      = 1'b1;
                pos_next   = pos_reg + 1'b1;
                state_next = ST_SHIFT_RD;
            end
            ST_RESP:
            begin
                if (res_take)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign res_valid = (state_reg == ST_RESP);
    assign res       = res_reg;

endmodule

`default_nettype wire

/* hw/rtl/deque_with_delete_by_value.sv */
// Bounded deque of handles with prepend, append, dequeue from front and delete of the
// first matching entry. One word in gives one result word out, one request at a time.
// Delete scans the entries from the front up to the match and then moves each entry
// behind it one slot forward; the memory has one read port with a registered read.
// A finished result waits in the output register while the next request is taken.
// Depends on dqdel_pkg, dqdel_ctrl and dqdel_ram.
`default_nettype none

module deque_with_delete_by_value
    import dqdel_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        action,
    input  wire logic [WORD_W-1:0] item_value,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   status,
    output logic      [WORD_W-1:0] item_out,
    output logic                   found,
    output logic      [CNT_W-1:0]  length
);

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [ITEM_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [ITEM_BITS-1:0] rd_data;
    logic                 res_valid;
    logic                 res_take;
    result_t              res;
    logic                 out_valid_reg;
    result_t              out_word_reg;

    dqdel_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .item      (item_value[ITEM_BITS-1:0]),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    dqdel_ram #(
        .WIDTH (ITEM_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_take)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
            out_word_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_word_reg.status;
    assign item_out  = WORD_W'(out_word_reg.item);
    assign found     = out_word_reg.found;
    assign length    = out_word_reg.length;

endmodule

`default_nettype wire
